### hdl/pinhole_primary_ray_generator_defines.svh
// Assertion macros for the pinhole primary ray generator.
// Included by the top level; no other dependencies.
`ifndef PINHOLE_PRIMARY_RAY_GENERATOR_DEFINES_SVH
`define PINHOLE_PRIMARY_RAY_GENERATOR_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define PRG_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define PRG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/prg_pkg.sv
// Shared types and constants of the pinhole primary ray generator.
// No dependencies.
package prg_pkg;

    localparam int PIXEL_FRAC_BITS = 4;
    localparam int DIR_FRAC_BITS   = 14;

    localparam int PIX_W   = 16;
    localparam int CFG_W   = 32;
    localparam int DIR_W   = 16;
    localparam int NUM_CFG = 8;
    localparam int ADDR_W  = $clog2(NUM_CFG);

    localparam int PROD_W  = PIX_W + CFG_W + 1;          // signed product
    localparam int DIFF_W  = PROD_W;                     // signed direction
    localparam int AMAG_W  = DIFF_W - 1;                 // raw magnitude
    localparam int POS_W   = $clog2(AMAG_W);
    localparam int MAG_W   = 30;                         // normalized magnitude
    localparam int SQ_W    = 2 * MAG_W;
    localparam int SUM_W   = SQ_W + 2;
    localparam int ROOT_W  = SUM_W / 2;
    localparam int REM_W   = ROOT_W + 2;
    localparam int QW      = DIR_FRAC_BITS + 1;
    localparam int NUM_W   = MAG_W + DIR_FRAC_BITS + 1;
    localparam int DREM_W  = ROOT_W + 1;

    typedef enum logic [ADDR_W-1:0] {
        REG_CAM_POS_X  = 3'd0,
        REG_CAM_POS_Y  = 3'd1,
        REG_CAM_POS_Z  = 3'd2,
        REG_CORNER_X   = 3'd3,
        REG_CORNER_Y   = 3'd4,
        REG_CORNER_Z   = 3'd5,
        REG_STEP_ACROSS = 3'd6,
        REG_STEP_DOWN  = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_x;
        logic [PIX_W-1:0] pixel_y;
    } in_t;

    typedef struct packed {
        logic signed [CFG_W-1:0] origin_x;
        logic signed [CFG_W-1:0] origin_y;
        logic signed [CFG_W-1:0] origin_z;
        logic signed [DIR_W-1:0] dir_x;
        logic signed [DIR_W-1:0] dir_y;
        logic signed [DIR_W-1:0] dir_z;
        logic                    degenerate;
    } out_t;

    // camera setup seen by the front stages
    typedef struct packed {
        logic signed [CFG_W-1:0] cam_x;
        logic signed [CFG_W-1:0] cam_y;
        logic signed [CFG_W-1:0] cam_z;
        logic signed [CFG_W-1:0] corner_x;
        logic signed [CFG_W-1:0] corner_y;
        logic signed [CFG_W-1:0] corner_z;
        logic signed [CFG_W-1:0] step_across;
        logic signed [CFG_W-1:0] step_down;
    } cam_t;

    // normalized direction carried alongside the length computation
    typedef struct packed {
        logic [2:0][MAG_W-1:0] mag;
        logic [2:0]            neg;
        logic                  degen;
    } vec_t;

endpackage

### hdl/pinhole_primary_ray_generator.sv
// Pinhole primary ray generator: one pixel coordinate in, one unit-length ray out.
// Depends on prg_pkg, prg_front, prg_sqrt, prg_div and the defines header.
//
// Usage:
//   s_valid/s_ready/s_data carry pixel coordinates (unsigned 12.4), one per
//   transaction. m_valid/m_ready/m_data return the ray: origin (camera
//   position), unit direction in Q2.14 and the degenerate flag.
//   cfg_wr_en/cfg_addr/cfg_wdata write the camera setup registers; write only
//   while no transaction is in flight.
//   Throughput: one pixel per cycle while the skid register is empty. From
//   acceptance to m_valid a pixel passes the 7 front stages, 31 square-root
//   stages (one root bit each), a divider lane per axis (entry with rounding
//   term, one quotient bit per stage, sign/saturation), and the output register.
//   When the receiver stalls, the item leaving the pipeline lands in a skid
//   register and the whole pipeline then holds; s_ready drops only while the
//   skid register is full, so input keeps flowing while a result waits.
//   Reset (aresetn low, synchronous) clears all valid bits, empties the output
//   and skid registers and sets every configuration register to zero.
`include "pinhole_primary_ray_generator_defines.svh"
module pinhole_primary_ray_generator (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  prg_pkg::in_t               s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output prg_pkg::out_t              m_data,
    input  logic                       cfg_wr_en,
    input  logic [prg_pkg::ADDR_W-1:0] cfg_addr,
    input  logic [prg_pkg::CFG_W-1:0]  cfg_wdata
);
    import prg_pkg::*;

    cam_t cam_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cam_reg <= '0;
        end else if (cfg_wr_en) begin
            case (reg_idx_t'(cfg_addr))
                REG_CAM_POS_X:   cam_reg.cam_x       <= cfg_wdata;
                REG_CAM_POS_Y:   cam_reg.cam_y       <= cfg_wdata;
                REG_CAM_POS_Z:   cam_reg.cam_z       <= cfg_wdata;
                REG_CORNER_X:    cam_reg.corner_x    <= cfg_wdata;
                REG_CORNER_Y:    cam_reg.corner_y    <= cfg_wdata;
                REG_CORNER_Z:    cam_reg.corner_z    <= cfg_wdata;
                REG_STEP_ACROSS: cam_reg.step_across <= cfg_wdata;
                REG_STEP_DOWN:   cam_reg.step_down   <= cfg_wdata;
                default:         cam_reg             <= cam_reg;
            endcase
        end
    end

    logic en;
    logic skid_full_reg;

    assign en      = !skid_full_reg;
    assign s_ready = en;

    logic                     front_valid;
    logic [SUM_W-1:0]         front_sum;
    vec_t                     front_vec;
    logic                     sq_valid;
    logic [ROOT_W-1:0]        sq_root;
    vec_t                     sq_vec;
    logic [2:0]               lane_valid, lane_degen;
    logic signed [DIR_W-1:0]  lane_dir [3];

    prg_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .in_data   (s_data),
        .cam       (cam_reg),
        .out_valid (front_valid),
        .out_sum   (front_sum),
        .out_vec   (front_vec)
    );

    prg_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (front_valid),
        .in_sum    (front_sum),
        .in_vec    (front_vec),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_vec   (sq_vec)
    );

    for (genvar k = 0; k < 3; k++) begin : g_lane
        prg_div u_div (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (sq_valid),
            .in_mag    (sq_vec.mag[k]),
            .in_root   (sq_root),
            .in_neg    (sq_vec.neg[k]),
            .in_degen  (sq_vec.degen),
            .out_valid (lane_valid[k]),
            .out_dir   (lane_dir[k]),
            .out_degen (lane_degen[k])
        );
    end

    // direction part of a result; origin comes straight from the setup registers
    typedef struct packed {
        logic signed [DIR_W-1:0] dx;
        logic signed [DIR_W-1:0] dy;
        logic signed [DIR_W-1:0] dz;
        logic                    degen;
    } ray_dir_t;

    ray_dir_t pipe_dir;
    ray_dir_t out_reg, skid_reg;
    logic     out_valid_reg;
    logic     out_free;

    assign pipe_dir = '{dx: lane_dir[0], dy: lane_dir[1], dz: lane_dir[2],
                        degen: lane_degen[0]};
    assign out_free = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end else if (out_free) begin
            if (skid_full_reg) begin
                out_valid_reg <= 1'b1;
                skid_full_reg <= 1'b0;
            end else begin
                out_valid_reg <= lane_valid[0];
            end
        end else if (en && lane_valid[0]) begin
            skid_full_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            out_reg <= skid_full_reg ? skid_reg : pipe_dir;
        end else if (en && lane_valid[0]) begin
            skid_reg <= pipe_dir;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_data.origin_x   = cam_reg.cam_x;
    assign m_data.origin_y   = cam_reg.cam_y;
    assign m_data.origin_z   = cam_reg.cam_z;
    assign m_data.dir_x      = out_reg.dx;
    assign m_data.dir_y      = out_reg.dy;
    assign m_data.dir_z      = out_reg.dz;
    assign m_data.degenerate = out_reg.degen;

    `PRG_ASSERT_NOW(a_skid_behind_out, aclk, aresetn, skid_full_reg, out_valid_reg, "skid holds data while output is empty")
    `PRG_ASSERT_NEXT(a_skid_drains, aclk, aresetn, skid_full_reg && m_ready, !skid_full_reg, "skid did not drain on output transaction")
    `PRG_ASSERT_NOW(a_degen_zero_dir, aclk, aresetn, m_valid && m_data.degenerate, m_data.dir_x == '0 && m_data.dir_y == '0 && m_data.dir_z == '0, "degenerate ray with nonzero direction")
    `PRG_ASSERT_NOW(a_lanes_aligned, aclk, aresetn, 1'b1, lane_valid[0] == lane_valid[1] && lane_valid[0] == lane_valid[2], "divider lanes out of step")

endmodule

### hdl/prg_front.sv
// Front stages: pixel step products, direction, magnitude normalization, squared length.
// Depends on prg_pkg.
module prg_front (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     en,
    input  logic                     in_valid,
    input  prg_pkg::in_t             in_data,
    input  prg_pkg::cam_t            cam,
    output logic                     out_valid,
    output logic [prg_pkg::SUM_W-1:0] out_sum,
    output prg_pkg::vec_t            out_vec
);
    import prg_pkg::*;

    function automatic logic [POS_W-1:0] lead_pos(input logic [AMAG_W-1:0] v);
        logic [POS_W-1:0] p;
        p = '0;
        for (int i = 0; i < AMAG_W; i++) begin
            if (v[i]) p = POS_W'(i);
        end
        return p;
    endfunction

    logic [6:0] v_reg;

    logic signed [PROD_W-1:0] prod_x_reg, prod_y_reg;
    logic signed [DIFF_W-1:0] d_reg [3];
    logic [AMAG_W-1:0]        amag_reg [3];
    logic [AMAG_W-1:0]        orm_reg;
    logic [2:0]               neg3_reg, neg4_reg, neg5_reg, neg6_reg, neg7_reg;
    logic [AMAG_W-1:0]        amag4_reg [3];
    logic [POS_W-1:0]         pos_reg;
    logic                     zero4_reg, zero5_reg, zero6_reg, zero7_reg;
    logic [2:0][MAG_W-1:0]    mag5_reg, mag6_reg, mag7_reg;
    logic [SQ_W-1:0]          sq_reg [3];
    logic [SUM_W-1:0]         sum_reg;

    logic signed [DIFF_W-1:0] d_next [3];
    logic [AMAG_W-1:0]        amag_next [3];
    logic [2:0][MAG_W-1:0]    mag_next;

    always_comb begin
        d_next[0] = DIFF_W'(cam.corner_x) + (prod_x_reg >>> PIXEL_FRAC_BITS)
                  - DIFF_W'(cam.cam_x);
        d_next[1] = DIFF_W'(cam.corner_y) + (prod_y_reg >>> PIXEL_FRAC_BITS)
                  - DIFF_W'(cam.cam_y);
        d_next[2] = DIFF_W'(cam.corner_z) - DIFF_W'(cam.cam_z);
        for (int i = 0; i < 3; i++) begin
            amag_next[i] = d_reg[i][DIFF_W-1] ? AMAG_W'(-d_reg[i]) : AMAG_W'(d_reg[i]);
        end
        // bring the largest magnitude into [2^29, 2^30)
        for (int i = 0; i < 3; i++) begin
            if (pos_reg > POS_W'(MAG_W - 1)) begin
                mag_next[i] = MAG_W'(amag4_reg[i] >> (pos_reg - POS_W'(MAG_W - 1)));
            end else begin
                mag_next[i] = MAG_W'(amag4_reg[i] << (POS_W'(MAG_W - 1) - pos_reg));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[5:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_x_reg <= PROD_W'($signed({1'b0, in_data.pixel_x}))
                        * PROD_W'(cam.step_across);
            prod_y_reg <= PROD_W'($signed({1'b0, in_data.pixel_y}))
                        * PROD_W'(cam.step_down);
            for (int i = 0; i < 3; i++) begin
                d_reg[i]     <= d_next[i];
                amag_reg[i]  <= amag_next[i];
                amag4_reg[i] <= amag_reg[i];
                sq_reg[i]    <= mag5_reg[i] * mag5_reg[i];
            end
            neg3_reg  <= {d_reg[2][DIFF_W-1], d_reg[1][DIFF_W-1], d_reg[0][DIFF_W-1]};
            orm_reg   <= amag_next[0] | amag_next[1] | amag_next[2];
            pos_reg   <= lead_pos(orm_reg);
            zero4_reg <= (orm_reg == '0);
            neg4_reg  <= neg3_reg;
            mag5_reg  <= mag_next;
            zero5_reg <= zero4_reg;
            neg5_reg  <= neg4_reg;
            mag6_reg  <= mag5_reg;
            zero6_reg <= zero5_reg;
            neg6_reg  <= neg5_reg;
            sum_reg   <= SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
            mag7_reg  <= mag6_reg;
            zero7_reg <= zero6_reg;
            neg7_reg  <= neg6_reg;
        end
    end

    assign out_valid     = v_reg[6];
    assign out_sum       = zero7_reg ? '0 : sum_reg;
    assign out_vec.mag   = zero7_reg ? '0 : mag7_reg;
    assign out_vec.neg   = neg7_reg;
    assign out_vec.degen = zero7_reg;

endmodule

### hdl/prg_sqrt.sv
// Pipelined integer square root, one result bit per stage.
// Depends on prg_pkg.
module prg_sqrt (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [prg_pkg::SUM_W-1:0]  in_sum,
    input  prg_pkg::vec_t              in_vec,
    output logic                       out_valid,
    output logic [prg_pkg::ROOT_W-1:0] out_root,
    output prg_pkg::vec_t              out_vec
);
    import prg_pkg::*;

    logic [REM_W-1:0]  rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    logic [SUM_W-1:0]  rad_reg  [ROOT_W];
    vec_t              vec_reg  [ROOT_W];
    logic [ROOT_W-1:0] v_reg;

    for (genvar i = 0; i < ROOT_W; i++) begin : g_step
        logic [REM_W-1:0]  rem_in, rem_t, trial, rem_next;
        logic [ROOT_W-1:0] root_in, root_next;
        logic [SUM_W-1:0]  rad_in;
        vec_t              vec_in;
        logic              v_in;

        if (i == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = in_sum;
            assign vec_in  = in_vec;
            assign v_in    = in_valid;
        end else begin : g_rest
            assign rem_in  = rem_reg[i-1];
            assign root_in = root_reg[i-1];
            assign rad_in  = rad_reg[i-1];
            assign vec_in  = vec_reg[i-1];
            assign v_in    = v_reg[i-1];
        end

        always_comb begin
            rem_t = {rem_in[REM_W-3:0], rad_in[SUM_W-1 -: 2]};
            trial = {root_in, 2'b01};
            if (rem_t >= trial) begin
                rem_next  = rem_t - trial;
                root_next = {root_in[ROOT_W-2:0], 1'b1};
            end else begin
                rem_next  = rem_t;
                root_next = {root_in[ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i] <= 1'b0;
            end else if (en) begin
                v_reg[i] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i]  <= rem_next;
                root_reg[i] <= root_next;
                rad_reg[i]  <= rad_in << 2;
                vec_reg[i]  <= vec_in;
            end
        end
    end

    assign out_valid = v_reg[ROOT_W-1];
    assign out_root  = root_reg[ROOT_W-1];
    assign out_vec   = vec_reg[ROOT_W-1];

endmodule

### hdl/prg_div.sv
// One direction lane: rounded quotient mag * 2^DIR_FRAC_BITS / length,
// one quotient bit per stage, then sign and saturation. Depends on prg_pkg.
module prg_div (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic [prg_pkg::MAG_W-1:0]       in_mag,
    input  logic [prg_pkg::ROOT_W-1:0]      in_root,
    input  logic                            in_neg,
    input  logic                            in_degen,
    output logic                            out_valid,
    output logic signed [prg_pkg::DIR_W-1:0] out_dir,
    output logic                            out_degen
);
    import prg_pkg::*;

    localparam logic [CFG_W-1:0] POS_LIM = CFG_W'(32767);
    localparam logic [CFG_W-1:0] NEG_LIM = CFG_W'(32768);

    logic [NUM_W-1:0]  num_reg;
    logic [ROOT_W-1:0] r0_reg;
    logic              neg0_reg, degen0_reg, v0_reg;

    logic [DREM_W-1:0] rem_reg   [QW];
    logic [QW-1:0]     q_reg     [QW];
    logic [QW-1:0]     nlow_reg  [QW];
    logic [ROOT_W-1:0] r_reg     [QW];
    logic [QW-1:0]     neg_reg, degen_reg, v_reg;

    logic signed [DIR_W-1:0] dir_reg;
    logic                    degen_out_reg, v_out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg    <= 1'b0;
            v_out_reg <= 1'b0;
        end else if (en) begin
            v0_reg    <= in_valid;
            v_out_reg <= v_reg[QW-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            num_reg    <= (NUM_W'(in_mag) << DIR_FRAC_BITS) + NUM_W'(in_root >> 1);
            r0_reg     <= in_root;
            neg0_reg   <= in_neg;
            degen0_reg <= in_degen;
        end
    end

    for (genvar j = 0; j < QW; j++) begin : g_step
        logic [DREM_W-1:0] rem_in, rem_next;
        logic [DREM_W:0]   t;
        logic [QW-1:0]     q_in, nlow_in;
        logic [ROOT_W-1:0] r_in;
        logic              neg_in, degen_in, v_in, qbit;

        if (j == 0) begin : g_first
            assign rem_in   = DREM_W'(num_reg >> QW);
            assign q_in     = '0;
            assign nlow_in  = num_reg[QW-1:0];
            assign r_in     = r0_reg;
            assign neg_in   = neg0_reg;
            assign degen_in = degen0_reg;
            assign v_in     = v0_reg;
        end else begin : g_rest
            assign rem_in   = rem_reg[j-1];
            assign q_in     = q_reg[j-1];
            assign nlow_in  = nlow_reg[j-1];
            assign r_in     = r_reg[j-1];
            assign neg_in   = neg_reg[j-1];
            assign degen_in = degen_reg[j-1];
            assign v_in     = v_reg[j-1];
        end

        always_comb begin
            t    = {rem_in, nlow_in[QW-1]};
            qbit = (t >= (DREM_W + 1)'(r_in));
            if (qbit) begin
                rem_next = DREM_W'(t - (DREM_W + 1)'(r_in));
            end else begin
                rem_next = DREM_W'(t);
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[j] <= 1'b0;
            end else if (en) begin
                v_reg[j] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j]   <= rem_next;
                q_reg[j]     <= {q_in[QW-2:0], qbit};
                nlow_reg[j]  <= nlow_in << 1;
                r_reg[j]     <= r_in;
                neg_reg[j]   <= neg_in;
                degen_reg[j] <= degen_in;
            end
        end
    end

    logic [CFG_W-1:0]        qe;
    logic signed [DIR_W-1:0] dir_next;

    always_comb begin
        qe = CFG_W'(q_reg[QW-1]);
        if (qe > NEG_LIM) qe = NEG_LIM;
        if (degen_reg[QW-1]) begin
            dir_next = '0;
        end else if (neg_reg[QW-1]) begin
            dir_next = DIR_W'(-qe);
        end else if (qe > POS_LIM) begin
            dir_next = DIR_W'(POS_LIM);
        end else begin
            dir_next = DIR_W'(qe);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dir_reg       <= dir_next;
            degen_out_reg <= degen_reg[QW-1];
        end
    end

    assign out_valid = v_out_reg;
    assign out_dir   = dir_reg;
    assign out_degen = degen_out_reg;

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the pinhole primary ray generator.
// Depends on prg_pkg and the pinhole_primary_ray_generator RTL.
module testbench;
    import prg_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_t         s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_t        m_data;
    logic        cfg_wr_en = 1'b0;
    logic [ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_W-1:0]  cfg_wdata = '0;
    logic        s_taken = 1'b0;

    pinhole_primary_ray_generator dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    logic signed [CFG_W-1:0] cam_regs [NUM_CFG];
    in_t  pixel_queue[$];
    out_t ray_queue[$];
    int   mismatches = 0;
    int   rays_checked = 0;
    int   degenerate_seen = 0;
    longint cycles = 0;
    int   burst_left = 0;
    int   gap_left = 0;
    int   stall_mode = 0;

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint unsigned root_of(longint unsigned n);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic out_t ray_for(in_t p);
        out_t o;
        longint d [3];
        longint unsigned mag [3];
        bit neg [3];
        longint unsigned m, s, r, q;
        longint v;
        d[0] = longint'(cam_regs[REG_CORNER_X])
             + floor_shift(longint'(p.pixel_x) * longint'(cam_regs[REG_STEP_ACROSS]),
                           PIXEL_FRAC_BITS) - longint'(cam_regs[REG_CAM_POS_X]);
        d[1] = longint'(cam_regs[REG_CORNER_Y])
             + floor_shift(longint'(p.pixel_y) * longint'(cam_regs[REG_STEP_DOWN]),
                           PIXEL_FRAC_BITS) - longint'(cam_regs[REG_CAM_POS_Y]);
        d[2] = longint'(cam_regs[REG_CORNER_Z]) - longint'(cam_regs[REG_CAM_POS_Z]);
        o = '0;
        o.origin_x = cam_regs[REG_CAM_POS_X];
        o.origin_y = cam_regs[REG_CAM_POS_Y];
        o.origin_z = cam_regs[REG_CAM_POS_Z];
        m = 0;
        for (int i = 0; i < 3; i++) begin
            neg[i] = d[i] < 0;
            mag[i] = neg[i] ? longint'(-d[i]) : d[i];
            if (mag[i] > m) m = mag[i];
        end
        if (m == 0) begin
            o.degenerate = 1'b1;
            return o;
        end
        while (m >= (64'd1 << 30)) begin
            for (int i = 0; i < 3; i++) mag[i] >>= 1;
            m >>= 1;
        end
        while (m < (64'd1 << 29)) begin
            for (int i = 0; i < 3; i++) mag[i] <<= 1;
            m <<= 1;
        end
        s = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
        r = root_of(s);
        for (int i = 0; i < 3; i++) begin
            q = ((mag[i] << DIR_FRAC_BITS) + (r >> 1)) / r;
            if (q > 32768) q = 32768;
            v = neg[i] ? -longint'(q) : longint'(q);
            if (v > 32767) v = 32767;
            if (i == 0) o.dir_x = v[15:0];
            else if (i == 1) o.dir_y = v[15:0];
            else o.dir_z = v[15:0];
        end
        return o;
    endfunction

    // record the input handshake as seen at the rising edge
    always @(posedge aclk) begin
        s_taken <= aresetn && s_valid && s_ready;
    end

    // driver: bursts with random gaps, payload held until accepted
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_taken) begin
                ray_queue.push_back(ray_for(s_data));
                void'(pixel_queue.pop_front());
            end
            if (s_valid && !s_taken) begin
                // hold
            end else if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (pixel_queue.size() > 0) begin
                s_valid <= 1'b1;
                s_data <= pixel_queue[0];
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 40);
                end else if (--burst_left == 0) begin
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                s_valid <= 1'b0;
            end
            // receiver stall pattern: free run, periodic, or random
            if (cycles % 200 == 0) stall_mode = $urandom_range(0, 2);
            case (stall_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= (cycles % 7) < 4;
                default: m_ready <= $urandom_range(0, 3) != 0;
            endcase
        end
    end

    // monitor
    always @(posedge aclk) begin
        cycles++;
        if (aresetn && m_valid && m_ready) begin
            if (ray_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected ray %h", m_data);
            end else begin
                out_t exp_ray;
                exp_ray = ray_queue.pop_front();
                rays_checked++;
                if (m_data.degenerate) degenerate_seen++;
                if (m_data !== exp_ray) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ray mismatch: expected %h got %h", exp_ray, m_data);
                end
            end
        end
        if (cycles > 400000) begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        cam_regs[idx] = val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic drain();
        while (pixel_queue.size() > 0 || s_valid || ray_queue.size() > 0)
            @(posedge aclk);
        repeat (70) @(posedge aclk);
    endtask

    task automatic random_camera(int style);
        for (int i = 0; i < NUM_CFG; i++) begin
            logic [CFG_W-1:0] v;
            case (style)
                0: v = $urandom;
                1: v = (i == REG_CAM_POS_X || i == REG_CORNER_Y) ? 32'h8000_0000
                                                                 : 32'h7fff_ffff;
                default: v = $urandom_range(0, 1) ? $urandom_range(0, 32'h0008_0000)
                                                  : -$urandom_range(0, 32'h0008_0000);
            endcase
            write_reg(reg_idx_t'(i), v);
        end
    endtask

    function automatic in_t any_pixel();
        in_t p;
        p.pixel_x = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 16'h0fff));
        p.pixel_y = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 16'h0fff));
        return p;
    endfunction

    initial begin
        for (int i = 0; i < NUM_CFG; i++) cam_regs[i] = '0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        // reset setup: all zero, every ray degenerate
        pixel_queue.push_back('{16'h0000, 16'h0000});
        pixel_queue.push_back('{16'hffff, 16'hffff});
        drain();
        // typical camera looking down -z
        write_reg(REG_CAM_POS_X, 32'h0000_0000);
        write_reg(REG_CAM_POS_Y, 32'h0000_0000);
        write_reg(REG_CAM_POS_Z, 32'h0001_0000);
        write_reg(REG_CORNER_X, 32'hffff_0000);
        write_reg(REG_CORNER_Y, 32'h0000_c000);
        write_reg(REG_CORNER_Z, 32'h0000_0000);
        write_reg(REG_STEP_ACROSS, 32'h0000_0100);
        write_reg(REG_STEP_DOWN, 32'hffff_ff00);
        pixel_queue.push_back('{16'h0000, 16'h0000});
        pixel_queue.push_back('{16'hffff, 16'h0000});
        pixel_queue.push_back('{16'h0000, 16'hffff});
        pixel_queue.push_back('{16'hffff, 16'hffff});
        pixel_queue.push_back('{16'h1000, 16'h0c00});
        pixel_queue.push_back('{16'h5555, 16'haaaa});
        pixel_queue.push_back('{16'h0001, 16'h8000});
        drain();
        // corner pixel hits camera exactly: degenerate; neighbor pixels are not
        write_reg(REG_CORNER_Z, 32'h0001_0000);
        write_reg(REG_CORNER_X, 32'h0000_0000);
        write_reg(REG_CORNER_Y, 32'h0000_0000);
        pixel_queue.push_back('{16'h0000, 16'h0000});
        pixel_queue.push_back('{16'h0001, 16'h0000});
        pixel_queue.push_back('{16'h0000, 16'h0001});
        drain();
        // extremes of every register
        random_camera(1);
        pixel_queue.push_back('{16'h0000, 16'h0000});
        pixel_queue.push_back('{16'hffff, 16'hffff});
        pixel_queue.push_back('{16'h8000, 16'h0001});
        drain();
        for (int phase = 0; phase < 6; phase++) begin
            random_camera(phase % 3);
            for (int n = 0; n < 215; n++) pixel_queue.push_back(any_pixel());
            drain();
        end
        $display("%0d rays checked, %0d degenerate, across 10 camera setups",
                 rays_checked, degenerate_seen);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

### sim.f
+incdir+hdl
hdl/prg_pkg.sv
hdl/prg_front.sv
hdl/prg_sqrt.sv
hdl/prg_div.sv
hdl/pinhole_primary_ray_generator.sv
test/testbench.sv
